[hdl/fpf_pkg.sv]
package fpf_pkg;

	localparam int LETTER_W        = 5;
	localparam int MAX_PATTERN_LEN = 10;
	localparam int LEN_W           = 4;
	localparam int LETTERS_W       = LETTER_W * MAX_PATTERN_LEN;
	localparam int RUN_W           = 17;
	localparam int SLOT_W          = 6;
	localparam int CFG_W           = 7;

	typedef logic [LETTER_W-1:0]  letter_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [LETTERS_W-1:0] letters_t;
	typedef logic [RUN_W-1:0]     run_t;
	typedef logic [MAX_PATTERN_LEN-1:0][LETTER_W-1:0] hist_t;

	localparam run_t MAX_WORD = RUN_W'(65536);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_LETTER = 1'b1;

	typedef struct packed {
		len_t     len;
		letters_t letters;
	} pat_entry_t;

	typedef struct packed {
		logic hit;
		run_t new_start;
	} match_t;

endpackage

[hdl/fpf_item_if.sv]
interface fpf_item_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [fpf_pkg::SLOT_W-1:0] slot;
	fpf_pkg::len_t             pattern_length;
	fpf_pkg::letters_t         pattern_letters;
	fpf_pkg::letter_t          letter;
	logic                      end_of_word;

	modport source (
		output valid, opcode, slot, pattern_length, pattern_letters, letter, end_of_word,
		input  ready
	);
	modport sink (
		input  valid, opcode, slot, pattern_length, pattern_letters, letter, end_of_word,
		output ready
	);
endinterface

[hdl/fpf_result_if.sv]
interface fpf_result_if;
	logic          valid;
	logic          ready;
	fpf_pkg::run_t run_length;
	fpf_pkg::run_t best_length;
	logic          word_done;

	modport source (
		output valid, run_length, best_length, word_done,
		input  ready
	);
	modport sink (
		input  valid, run_length, best_length, word_done,
		output ready
	);
endinterface

[hdl/fpf_pat_mem.sv]
module fpf_pat_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  fpf_pkg::pat_entry_t wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output fpf_pkg::pat_entry_t rdata
);

	fpf_pkg::pat_entry_t mem_q [DEPTH];
	fpf_pkg::pat_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/fpf_match.sv]
module fpf_match (
	input  fpf_pkg::pat_entry_t entry,
	input  fpf_pkg::hist_t      hist,
	input  fpf_pkg::run_t       pos,
	output fpf_pkg::match_t     res
);

	always_comb begin
		logic                       len_ok;
		logic                       eq;
		logic [fpf_pkg::LEN_W-1:0] k;
		len_ok = (entry.len != '0)
			&& (entry.len <= fpf_pkg::LEN_W'(fpf_pkg::MAX_PATTERN_LEN))
			&& (pos >= fpf_pkg::RUN_W'(entry.len));
		eq = 1'b1;
		for (int j = 0; j < fpf_pkg::MAX_PATTERN_LEN; j++) begin
			k = entry.len - fpf_pkg::LEN_W'(j + 1);
			if (len_ok && (fpf_pkg::LEN_W'(j) < entry.len)) begin
				if (hist[k] != entry.letters[j*fpf_pkg::LETTER_W +: fpf_pkg::LETTER_W]) begin
					eq = 1'b0;
				end
			end
		end
		res.hit       = len_ok && eq;
		res.new_start = pos - fpf_pkg::RUN_W'(entry.len) + fpf_pkg::RUN_W'(1);
	end

endmodule

[hdl/forbidden_pattern_free_run_core.sv]
// channel   direction  role
// item      in         pattern load or one word letter
// result    out        run and best length per letter
// cfg       in         active pattern count, write only
//
// a load is written while idle and the core stays idle; a letter goes idle, scan, fin, idle,
// scan reading n pattern slots, n being the active count capped at PATTERNS (none when zero)
// scan makes one pattern memory read per slot, and the read data is registered before matching
// arst_n clears word state, history and the count; the pattern memory is not cleared
// a finished result waits in the output register while the next request is taken;
// a letter that finds the output still full waits in its final cycle and blocks loads
module forbidden_pattern_free_run_core #(
	parameter int PATTERNS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fpf_pkg::CFG_W-1:0] cfg_wdata,
	fpf_item_if.sink                  item,
	fpf_result_if.source              result
);

	localparam int AW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
	localparam int CW = ($clog2(PATTERNS + 1) > fpf_pkg::CFG_W) ?
		$clog2(PATTERNS + 1) : fpf_pkg::CFG_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(PATTERNS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t                    state_q;
	logic [fpf_pkg::CFG_W-1:0] active_q;
	fpf_pkg::hist_t            hist_q;
	fpf_pkg::run_t             pos_q;
	fpf_pkg::run_t             ws_q;
	fpf_pkg::run_t             best_q;
	logic                      eow_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             cnt_q;
	logic                      rd_vld_s1;
	logic                      out_vld_q;
	fpf_pkg::run_t             run_q;
	fpf_pkg::run_t             best_out_q;
	logic                      done_q;

	logic                item_fire;
	logic                letter_fire;
	logic [CW-1:0]       slot_ext;
	logic [CW-1:0]       active_ext;
	logic [CW-1:0]       cnt_d;
	logic                mem_we;
	logic                rd_en;
	logic                fin_fire;
	fpf_pkg::run_t       run_d;
	fpf_pkg::run_t       best_d;
	fpf_pkg::pat_entry_t wr_entry;
	fpf_pkg::pat_entry_t rd_entry;
	fpf_pkg::match_t     match;

	assign item.ready  = (state_q == S_IDLE);
	assign item_fire   = item.valid && item.ready;
	assign letter_fire = item_fire && (item.opcode == fpf_pkg::OP_LETTER);
	assign slot_ext    = CW'(item.slot);
	assign active_ext  = CW'(active_q);
	assign cnt_d       = (active_ext > DEPTH_C) ? DEPTH_C : active_ext;
	assign mem_we      = item_fire && (item.opcode == fpf_pkg::OP_LOAD) && (slot_ext < DEPTH_C);
	assign rd_en       = (state_q == S_SCAN) && (idx_q != cnt_q);
	assign fin_fire    = (state_q == S_FIN) && (!out_vld_q || result.ready);
	assign run_d       = pos_q - ws_q;
	assign best_d      = (run_d > best_q) ? run_d : best_q;

	assign wr_entry.len     = item.pattern_length;
	assign wr_entry.letters = item.pattern_letters;

	fpf_pat_mem #(
		.DEPTH (PATTERNS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (slot_ext[AW-1:0]),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_entry)
	);

	fpf_match u_match (
		.entry (rd_entry),
		.hist  (hist_q),
		.pos   (pos_q),
		.res   (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			hist_q    <= '0;
			pos_q     <= '0;
			ws_q      <= '0;
			best_q    <= '0;
			eow_q     <= 1'b0;
			idx_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (state_q)
				S_IDLE: begin
					if (letter_fire) begin
						hist_q  <= {hist_q[fpf_pkg::MAX_PATTERN_LEN-2:0], item.letter};
						pos_q   <= (pos_q == fpf_pkg::MAX_WORD) ? pos_q : pos_q + fpf_pkg::RUN_W'(1);
						eow_q   <= item.end_of_word;
						idx_q   <= '0;
						cnt_q   <= cnt_d;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end
					if (rd_vld_s1 && match.hit && (match.new_start > ws_q)) begin
						ws_q <= match.new_start;
					end
					if (!rd_en && !rd_vld_s1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						if (eow_q) begin
							hist_q <= '0;
							pos_q  <= '0;
							ws_q   <= '0;
							best_q <= '0;
						end else begin
							best_q <= best_d;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			run_q      <= run_d;
			best_out_q <= best_d;
			done_q     <= eow_q;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.run_length  = run_q;
	assign result.best_length = best_out_q;
	assign result.word_done   = done_q;

endmodule

[sim/forbidden_pattern_free_run_core_test.sv]
`timescale 1ns / 1ps

module forbidden_pattern_free_run_core_test;

	localparam int PATTERNS     = 64;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 2000;
	localparam int PRINT_LIMIT  = 100;

	typedef struct packed {
		logic                       op;
		logic [fpf_pkg::SLOT_W-1:0] slot;
		fpf_pkg::len_t              len;
		fpf_pkg::letters_t          letters;
		fpf_pkg::letter_t           letter;
		logic                       eow;
	} request_t;

	typedef struct packed {
		fpf_pkg::run_t run;
		fpf_pkg::run_t best;
		logic          done;
	} runs_t;

	typedef struct packed {
		logic                      cfg_first;
		logic [fpf_pkg::CFG_W-1:0] cfg_value;
		request_t                  req;
		logic                      typed;
		runs_t                     runs;
	} script_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [fpf_pkg::CFG_W-1:0] cfg_wdata;

	fpf_item_if   item_ch ();
	fpf_result_if result_ch ();

	forbidden_pattern_free_run_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	always #6 clk = ~clk;

	// predictor state
	fpf_pkg::letter_t          history [fpf_pkg::MAX_PATTERN_LEN];
	fpf_pkg::run_t             word_pos;
	fpf_pkg::run_t             cut_start;
	fpf_pkg::run_t             best_run;
	fpf_pkg::letters_t         pattern_bits [PATTERNS];
	fpf_pkg::len_t             pattern_len [PATTERNS];
	logic [fpf_pkg::CFG_W-1:0] active_count;

	runs_t runs_due [$];
	int    error_count;
	int    stall_cycles;
	bit    idle_on;
	bit    typed_next;
	runs_t typed_runs;
	runs_t seen;
	runs_t want;

	function automatic void clear_word();
		for (int i = 0; i < fpf_pkg::MAX_PATTERN_LEN; i++) history[i] = '0;
		word_pos  = '0;
		cut_start = '0;
		best_run  = '0;
	endfunction

	function automatic runs_t next_runs(fpf_pkg::letter_t ch, logic eow);
		runs_t         r;
		int            n;
		int            l;
		bit            hit;
		fpf_pkg::run_t ns;
		for (int i = fpf_pkg::MAX_PATTERN_LEN - 1; i > 0; i--) history[i] = history[i-1];
		history[0] = ch;
		if (word_pos < fpf_pkg::MAX_WORD) word_pos = word_pos + 1'b1;
		n = (active_count > PATTERNS) ? PATTERNS : active_count;
		for (int s = 0; s < n; s++) begin
			l = pattern_len[s];
			if (l != 0 && l <= fpf_pkg::MAX_PATTERN_LEN && word_pos >= fpf_pkg::run_t'(l)) begin
				hit = 1'b1;
				for (int j = 0; j < l; j++)
					if (history[l-1-j] !=
						pattern_bits[s][fpf_pkg::LETTER_W*j +: fpf_pkg::LETTER_W]) hit = 1'b0;
				if (hit) begin
					ns = word_pos - fpf_pkg::run_t'(l) + 1'b1;
					if (ns > cut_start) cut_start = ns;
				end
			end
		end
		r.run  = word_pos - cut_start;
		if (r.run > best_run) best_run = r.run;
		r.best = best_run;
		r.done = eow;
		if (eow) clear_word();
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
	endtask

	function automatic request_t load_req(logic [fpf_pkg::SLOT_W-1:0] slot, fpf_pkg::len_t len,
			fpf_pkg::letters_t bits, logic eow);
		request_t r;
		r = '0;
		r.op      = fpf_pkg::OP_LOAD;
		r.slot    = slot;
		r.len     = len;
		r.letters = bits;
		r.letter  = fpf_pkg::letter_t'($urandom);
		r.eow     = eow;
		return r;
	endfunction

	function automatic request_t letter_req(fpf_pkg::letter_t ch, logic eow);
		request_t r;
		r = '0;
		r.op      = fpf_pkg::OP_LETTER;
		r.slot    = fpf_pkg::SLOT_W'($urandom);
		r.len     = fpf_pkg::len_t'($urandom);
		r.letters = fpf_pkg::letters_t'({$urandom, $urandom});
		r.letter  = ch;
		r.eow     = eow;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (result_ch.valid && result_ch.ready) begin
				stall_cycles = 0;
				seen.run  = result_ch.run_length;
				seen.best = result_ch.best_length;
				seen.done = result_ch.word_done;
				if (runs_due.size() == 0) begin
					report_mismatch($sformatf("result with no request pending: run %0d best %0d",
						seen.run, seen.best));
				end else begin
					want = runs_due.pop_front();
					if (seen.run !== want.run)
						report_mismatch($sformatf("run_length %0d, want %0d", seen.run, want.run));
					if (seen.best !== want.best)
						report_mismatch($sformatf("best_length %0d, want %0d", seen.best, want.best));
					if (seen.done !== want.done)
						report_mismatch($sformatf("word_done %0b, want %0b", seen.done, want.done));
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				stall_cycles = 0;
				if (item_ch.opcode == fpf_pkg::OP_LOAD) begin
					pattern_bits[item_ch.slot] = item_ch.pattern_letters;
					pattern_len[item_ch.slot]  = item_ch.pattern_length;
				end else begin
					want = next_runs(item_ch.letter, item_ch.end_of_word);
					runs_due.push_back(typed_next ? typed_runs : want);
				end
			end
			if (cfg_we) begin
				stall_cycles = 0;
				active_count = cfg_wdata;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("forbidden_pattern_free_run_core_test: done, errors");
				$finish;
			end
		end
	end

	// result side backpressure
	initial begin
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0 && idle_on) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 10) - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_item(request_t req);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.opcode          <= req.op;
		item_ch.slot            <= req.slot;
		item_ch.pattern_length  <= req.len;
		item_ch.pattern_letters <= req.letters;
		item_ch.letter          <= req.letter;
		item_ch.end_of_word     <= req.eow;
		item_ch.valid           <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_config(logic [fpf_pkg::CFG_W-1:0] value);
		item_ch.valid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_phase(logic [fpf_pkg::CFG_W-1:0] setting, int count, bit idle);
		int                sent;
		int                n_slots;
		int                s;
		int                bad;
		int                pick;
		request_t          req;
		fpf_pkg::letters_t bits;
		fpf_pkg::len_t     len;
		write_config(setting);
		idle_on = idle;
		n_slots = (active_count > PATTERNS) ? PATTERNS : active_count;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				bits = fpf_pkg::letters_t'({$urandom, $urandom});
				if ($urandom_range(0, 3) != 0) begin
					len = fpf_pkg::len_t'($urandom_range(1, 4));
					for (int j = 0; j < len; j++)
						bits[fpf_pkg::LETTER_W*j +: fpf_pkg::LETTER_W] =
							fpf_pkg::letter_t'($urandom_range(0, 3));
				end else begin
					len = fpf_pkg::len_t'($urandom);
				end
				send_item(load_req(fpf_pkg::SLOT_W'($urandom), len, bits, logic'($urandom)));
				sent++;
			end else if (pick == 2 && n_slots > 0) begin
				s = $urandom_range(0, n_slots - 1);
				if (pattern_len[s] != 0 && pattern_len[s] <= fpf_pkg::MAX_PATTERN_LEN) begin
					bad = -1;
					if ($urandom_range(0, 3) == 0) bad = $urandom_range(0, pattern_len[s] - 1);
					for (int j = 0; j < pattern_len[s]; j++) begin
						req = letter_req(
							pattern_bits[s][fpf_pkg::LETTER_W*j +: fpf_pkg::LETTER_W], 1'b0);
						if (j == bad) req.letter = req.letter ^ fpf_pkg::letter_t'(1);
						send_item(req);
						sent++;
					end
				end
			end else begin
				if (pick < 8) req = letter_req(fpf_pkg::letter_t'($urandom_range(0, 3)), 1'b0);
				else req = letter_req(fpf_pkg::letter_t'($urandom), 1'b0);
				req.eow = ($urandom_range(0, 24) == 0);
				send_item(req);
				sent++;
			end
		end
	endtask

	initial begin
		script_row_t script [$];
		script_row_t row;
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_wdata               = '0;
		item_ch.valid           = 1'b0;
		item_ch.opcode          = fpf_pkg::OP_LOAD;
		item_ch.slot            = '0;
		item_ch.pattern_length  = '0;
		item_ch.pattern_letters = '0;
		item_ch.letter          = '0;
		item_ch.end_of_word     = 1'b0;
		error_count             = 0;
		stall_cycles            = 0;
		idle_on                 = 1'b1;
		typed_next              = 1'b0;
		typed_runs              = '0;
		active_count            = '0;
		clear_word();
		for (int s = 0; s < PATTERNS; s++) begin
			pattern_bits[s] = '0;
			pattern_len[s]  = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every slot gets an empty pattern before any count above zero
		for (int s = 0; s < PATTERNS; s++)
			send_item(load_req(fpf_pkg::SLOT_W'(s), '0,
				fpf_pkg::letters_t'({$urandom, $urandom}), logic'($urandom)));

		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b0), 1'b1, '{17'd1, 17'd1, 1'b0}});
		script.push_back('{1'b0, '0, letter_req(5'd31, 1'b0), 1'b1, '{17'd2, 17'd2, 1'b0}});
		script.push_back('{1'b0, '0, letter_req(5'd25, 1'b1), 1'b1, '{17'd3, 17'd3, 1'b1}});
		script.push_back('{1'b0, '0, letter_req(5'd7, 1'b0), 1'b1, '{17'd1, 17'd1, 1'b0}});
		script.push_back('{1'b0, '0, load_req(6'd0, 4'd2,
			fpf_pkg::letters_t'(50'd1 | (50'd2 << 5)), 1'b1), 1'b0, '0});
		script.push_back('{1'b0, '0, load_req(6'd1, 4'd0, {10{5'd1}}, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, load_req(6'd2, 4'd15, {10{5'd1}}, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, load_req(6'd3, 4'd3, '0, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, load_req(6'd63, 4'd1, fpf_pkg::letters_t'(5'd31), 1'b0),
			1'b0, '0});
		script.push_back('{1'b1, 7'd64, letter_req(5'd0, 1'b1), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd1, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd2, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd1, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd31, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd0, 1'b1), 1'b0, '0});
		script.push_back('{1'b1, 7'd127, letter_req(5'd1, 1'b0), 1'b0, '0});
		script.push_back('{1'b0, '0, letter_req(5'd2, 1'b0), 1'b0, '0});
		script.push_back('{1'b1, 7'd0, letter_req(5'd1, 1'b1), 1'b0, '0});

		foreach (script[i]) begin
			row = script[i];
			if (row.cfg_first) write_config(row.cfg_value);
			typed_next = row.typed;
			typed_runs = row.runs;
			send_item(row.req);
			typed_next = 1'b0;
		end

		random_phase(7'd1, 85, 1'b1);
		random_phase(7'd64, 85, 1'b1);
		random_phase(7'd127, 85, 1'b1);
		random_phase(fpf_pkg::CFG_W'($urandom_range(2, 63)), 85, 1'b1);
		random_phase(fpf_pkg::CFG_W'($urandom), 85, 1'b1);
		random_phase(7'd8, 85, 1'b0);

		item_ch.valid <= 1'b0;
		while (runs_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("forbidden_pattern_free_run_core_test: done, clean");
		end else begin
			$display("forbidden_pattern_free_run_core_test: done, errors");
		end
		$finish;
	end

endmodule
